// ===== hw/rtl/lsig_pkg.sv =====
// ----------------------------------------------------------------------------
// lsig_pkg
// Shared formats, constants and types of the logistic sigmoid unit. All
// internal arithmetic runs in unsigned Q.56 fixed point.
// ----------------------------------------------------------------------------
package lsig_pkg;

  // Internal fixed-point format.
  localparam int unsigned Q_FRAC = 56;

  // Widths of the internal words.
  localparam int unsigned ARG_W  = 62;  // |x| in Q.56, below 48.0
  localparam int unsigned R_W    = 56;  // reduced argument, below ln2
  localparam int unsigned TERM_W = 57;  // series term, at most 1.0
  localparam int unsigned SUM_W  = 64;  // running series sum
  localparam int unsigned N_W    = 7;   // power-of-two count of exp(-|x|)
  localparam int unsigned DIV_W  = 58;  // divider remainder and divisor
  localparam int unsigned K_W    = 5;   // series index

  // Series length and the number of quotient bits in the range reduction.
  localparam int unsigned TAYLOR_TERMS = 24;
  localparam int unsigned RED_BITS     = N_W;

  // ln2 in Q.56, one in Q.56 and the magnitude at or above which exp(-|x|) is nil.
  localparam logic [R_W-1:0]    Q_LN2     = 56'hB17217F7D1CF7A;
  localparam logic [TERM_W-1:0] Q_ONE     = {1'b1, {Q_FRAC{1'b0}}};
  localparam logic [63:0]       BIG_LIMIT = 64'd48;

  typedef logic [ARG_W-1:0]  arg_t;
  typedef logic [R_W-1:0]    red_t;
  typedef logic [TERM_W-1:0] term_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [N_W-1:0]    shift_t;
  typedef logic [DIV_W-1:0]  div_t;

  // Flags that ride along with each word.
  typedef struct packed {
    logic neg;   // sample was negative
    logic big;   // magnitude at or above the saturation limit
    logic last;  // end of tensor
  } lsig_tag_t;

  // Everything a series stage passes on besides the current term.
  typedef struct packed {
    red_t      r;
    sum_t      sum;
    shift_t    n;
    lsig_tag_t tag;
  } lsig_side_t;

endpackage

// ===== hw/rtl/lsig_term_step.sv =====
// ----------------------------------------------------------------------------
// lsig_term_step
// One term of the exp(-r) series: term_k = floor(floor(term * r / 2^56) / k),
// added to or taken from the running sum. Seven register stages; the wide
// products are split into 32-bit partial products and the division by k is a
// reciprocal multiplication followed by a one-step correction.
// ----------------------------------------------------------------------------
module lsig_term_step
  import lsig_pkg::*;
#(
  parameter int unsigned TERM_K = 1
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  term_t      in_term,
  input  lsig_side_t in_side,
  output logic       out_valid,
  output term_t      out_term,
  output lsig_side_t out_side
);

  localparam int unsigned DEPTH = 7;
  localparam logic [63:0] RECIP = 64'hFFFF_FFFF_FFFF_FFFF / TERM_K;
  localparam logic [K_W-1:0] K_C = K_W'(TERM_K);
  localparam bit ODD = (TERM_K % 2) == 1;

  logic [DEPTH-1:0] v_r;
  lsig_side_t       side_r [DEPTH];
  lsig_side_t       side_nxt;

  // Stage 1: partial products of term * r.
  logic [63:0] pp_ll_r;
  logic [55:0] pp_lh_r;
  logic [56:0] pp_hl_r;
  logic [48:0] pp_hh_r;
  // Stage 2: q = floor(term * r / 2^56).
  logic [112:0] prod_nxt;
  term_t        q2_r;
  // Stage 3: partial products of q * reciprocal.
  logic [63:0]  qm_ll_r;
  logic [63:0]  qm_lh_r;
  logic [56:0]  qm_hl_r;
  logic [56:0]  qm_hh_r;
  term_t        q3_r;
  // Stage 4: quotient estimate, low by at most one.
  logic [120:0] qm_nxt;
  term_t        est4_r;
  term_t        q4_r;
  // Stage 5: estimate times k.
  logic [61:0]  estk_r;
  term_t        est5_r;
  term_t        q5_r;
  // Stage 6: corrected term.
  logic [61:0]  rem6;
  logic         fix6;
  term_t        term6_r;
  // Stage 7: term passed on with the updated sum.
  term_t        term7_r;

  // Valid bits shift with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DEPTH-2:0], in_valid};
    end
  end

  // Wide sums of the partial products and the correction of the estimate.
  always_comb begin
    prod_nxt = 113'(pp_ll_r) + (113'(pp_lh_r) << 32) + (113'(pp_hl_r) << 32)
               + (113'(pp_hh_r) << 64);
    qm_nxt   = 121'(qm_ll_r) + (121'(qm_lh_r) << 32) + (121'(qm_hl_r) << 32)
               + (121'(qm_hh_r) << 64);
    rem6     = 62'(q5_r) - estk_r;
    fix6     = rem6 >= 62'(K_C);
  end

  // Odd terms are subtracted, even terms added.
  always_comb begin
    side_nxt = side_r[DEPTH-2];
    if (ODD) begin
      side_nxt.sum = side_r[DEPTH-2].sum - sum_t'(term6_r);
    end else begin
      side_nxt.sum = side_r[DEPTH-2].sum + sum_t'(term6_r);
    end
  end

  // Datapath registers; the whole chain holds while en is low.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= 64'(in_term[31:0]) * 64'(in_side.r[31:0]);
      pp_lh_r <= 56'(in_term[31:0]) * 56'(in_side.r[55:32]);
      pp_hl_r <= 57'(in_term[56:32]) * 57'(in_side.r[31:0]);
      pp_hh_r <= 49'(in_term[56:32]) * 49'(in_side.r[55:32]);

      q2_r    <= prod_nxt[112:56];

      qm_ll_r <= 64'(q2_r[31:0]) * 64'(RECIP[31:0]);
      qm_lh_r <= 64'(q2_r[31:0]) * 64'(RECIP[63:32]);
      qm_hl_r <= 57'(q2_r[56:32]) * 57'(RECIP[31:0]);
      qm_hh_r <= 57'(q2_r[56:32]) * 57'(RECIP[63:32]);
      q3_r    <= q2_r;

      est4_r  <= qm_nxt[120:64];
      q4_r    <= q3_r;

      estk_r  <= 62'(est4_r) * 62'(K_C);
      est5_r  <= est4_r;
      q5_r    <= q4_r;

      term6_r <= est5_r + term_t'(fix6);

      term7_r <= term6_r;

      side_r[0] <= in_side;
      for (int i = 1; i < DEPTH - 1; i++) begin
        side_r[i] <= side_r[i-1];
      end
      side_r[DEPTH-1] <= side_nxt;
    end
  end

  assign out_valid = v_r[DEPTH-1];
  assign out_term  = term7_r;
  assign out_side  = side_r[DEPTH-1];

  // The reciprocal estimate is never more than one below the true quotient.
  a_est_within_one: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] |-> rem6 < (62'(K_C) << 1))
    else $error("series quotient estimate off by more than one");

endmodule

// ===== hw/rtl/logistic_sigmoid_unit.sv =====
// ----------------------------------------------------------------------------
// logistic_sigmoid_unit
// Computes y = 1/(1+exp(-x)) for a signed fixed-point sample x (IN_WIDTH bits,
// IN_FRAC fraction bits) and returns it as unsigned with OUT_WIDTH fraction
// bits, saturated to all ones where it would reach 1.0; the last flag rides
// along unchanged. Unless a held result stalls it, the unit takes one word
// every clock cycle and holds up to OUT_WIDTH + 180 words in flight: a word
// passes a range reduction by ln2 of seven stages, a 24-term series for
// exp(-r) of seven stages per term, a shift stage, and a restoring divider
// that retires one quotient bit per stage. A result held by out_stall freezes
// the whole pipeline and in_stall follows it in the same cycle; nothing is
// dropped or repeated.
// ----------------------------------------------------------------------------
module logistic_sigmoid_unit
  import lsig_pkg::*;
#(
  parameter int unsigned IN_WIDTH  = 16,
  parameter int unsigned IN_FRAC   = 11,
  parameter int unsigned OUT_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [IN_WIDTH-1:0] in_x_value,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [OUT_WIDTH-1:0]       out_y_value,
  output logic                       out_last
);

  localparam int unsigned ARG_SHIFT = Q_FRAC - IN_FRAC;
  localparam logic [63:0] BIG_MAG   = BIG_LIMIT << IN_FRAC;
  localparam int unsigned QW        = OUT_WIDTH + 2;
  localparam int unsigned DIV_STEPS = OUT_WIDTH + 1;
  localparam logic [OUT_WIDTH-1:0] OUT_MAX = '1;

  logic adv;

  // The pipeline moves as one unless a finished result waits downstream.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Input: magnitude, sign and saturation check, scaled to Q.56.
  logic [IN_WIDTH-1:0] x_raw;
  logic [IN_WIDTH-1:0] x_mag;
  logic                x_neg;
  logic                x_big;
  arg_t                x_arg;

  always_comb begin
    x_raw = in_x_value;
    x_neg = x_raw[IN_WIDTH-1];
    x_mag = x_neg ? (~x_raw + IN_WIDTH'(1)) : x_raw;
    x_big = 64'(x_mag) >= BIG_MAG;
    x_arg = arg_t'(64'(x_mag) << ARG_SHIFT);
  end

  // Range reduction: n = floor(t / ln2) one bit per stage, r is the remainder.
  logic      red_v_r   [RED_BITS+1];
  arg_t      red_rem_r [RED_BITS+1];
  shift_t    red_n_r   [RED_BITS+1];
  lsig_tag_t red_tag_r [RED_BITS+1];
  logic      red_take  [RED_BITS];
  arg_t      red_step  [RED_BITS];

  always_comb begin
    for (int i = 0; i < RED_BITS; i++) begin
      red_step[i] = arg_t'(Q_LN2) << (RED_BITS - 1 - i);
      red_take[i] = red_rem_r[i] >= red_step[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= RED_BITS; i++) begin
        red_v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      red_v_r[0] <= in_valid;
      for (int i = 0; i < RED_BITS; i++) begin
        red_v_r[i+1] <= red_v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_rem_r[0] <= x_arg;
      red_n_r[0]   <= '0;
      red_tag_r[0] <= '{neg: x_neg, big: x_big, last: in_last};
      for (int i = 0; i < RED_BITS; i++) begin
        red_rem_r[i+1] <= red_take[i] ? red_rem_r[i] - red_step[i] : red_rem_r[i];
        red_n_r[i+1]   <= red_n_r[i] | (shift_t'(red_take[i]) << (RED_BITS - 1 - i));
        red_tag_r[i+1] <= red_tag_r[i];
      end
    end
  end

  // Series for exp(-r): one unit per term, starting from term and sum of one.
  logic       chain_v    [TAYLOR_TERMS+1];
  term_t      chain_term [TAYLOR_TERMS+1];
  lsig_side_t chain_side [TAYLOR_TERMS+1];

  assign chain_v[0]    = red_v_r[RED_BITS];
  assign chain_term[0] = Q_ONE;
  assign chain_side[0] = '{r:   red_t'(red_rem_r[RED_BITS]),
                           sum: sum_t'(Q_ONE),
                           n:   red_n_r[RED_BITS],
                           tag: red_tag_r[RED_BITS]};

  for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_term
    lsig_term_step #(
      .TERM_K (k)
    ) u_term (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (chain_v[k-1]),
      .in_term   (chain_term[k-1]),
      .in_side   (chain_side[k-1]),
      .out_valid (chain_v[k]),
      .out_term  (chain_term[k]),
      .out_side  (chain_side[k])
    );
  end

  // Scale by 2^-n: e approximates exp(-|x|) in Q.56.
  lsig_side_t sr_side;
  sum_t       exp_shifted;
  term_t      exp_e_nxt;
  logic       exp_v_r;
  term_t      exp_e_r;
  lsig_tag_t  exp_tag_r;

  always_comb begin
    sr_side     = chain_side[TAYLOR_TERMS];
    exp_shifted = sr_side.sum >> sr_side.n[N_W-2:0];
    exp_e_nxt   = sr_side.n[N_W-1] ? '0 : term_t'(exp_shifted);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_v_r <= 1'b0;
    end else if (adv) begin
      exp_v_r <= chain_v[TAYLOR_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      exp_e_r   <= exp_e_nxt;
      exp_tag_r <= sr_side.tag;
    end
  end

  // Restoring divider: num * 2^(OUT_WIDTH+1) / (1 + e), one bit per stage.
  logic            div_v_r   [DIV_STEPS+1];
  div_t            div_rem_r [DIV_STEPS+1];
  div_t            div_d_r   [DIV_STEPS+1];
  logic [QW-1:0]   div_q_r   [DIV_STEPS+1];
  lsig_tag_t       div_tag_r [DIV_STEPS+1];
  div_t            dv_d;
  div_t            dv_num;
  logic            dv_q0;
  logic [DIV_W:0]  div_rem2  [DIV_STEPS];
  logic            div_ge    [DIV_STEPS];

  always_comb begin
    dv_d   = div_t'(Q_ONE) + div_t'(exp_e_r);
    dv_num = exp_tag_r.neg ? div_t'(exp_e_r) : div_t'(Q_ONE);
    dv_q0  = dv_num >= dv_d;
    for (int i = 0; i < DIV_STEPS; i++) begin
      div_rem2[i] = {div_rem_r[i], 1'b0};
      div_ge[i]   = div_rem2[i] >= {1'b0, div_d_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
        div_v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      div_v_r[0] <= exp_v_r;
      for (int i = 0; i < DIV_STEPS; i++) begin
        div_v_r[i+1] <= div_v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_rem_r[0] <= dv_q0 ? dv_num - dv_d : dv_num;
      div_d_r[0]   <= dv_d;
      div_q_r[0]   <= QW'(dv_q0);
      div_tag_r[0] <= exp_tag_r;
      for (int i = 0; i < DIV_STEPS; i++) begin
        div_rem_r[i+1] <= div_ge[i] ? div_t'(div_rem2[i] - {1'b0, div_d_r[i]})
                                    : div_t'(div_rem2[i]);
        div_d_r[i+1]   <= div_d_r[i];
        div_q_r[i+1]   <= {div_q_r[i][QW-2:0], div_ge[i]};
        div_tag_r[i+1] <= div_tag_r[i];
      end
    end
  end

  // Output: round half up, saturate below one, force the large-magnitude cases.
  logic [QW-1:0]        out_rnd;
  logic [OUT_WIDTH:0]   out_full;
  logic [OUT_WIDTH-1:0] out_y_nxt;
  lsig_tag_t            out_tag;
  logic                 out_valid_r;
  logic [OUT_WIDTH-1:0] out_y_r;
  logic                 out_last_r;

  always_comb begin
    out_tag  = div_tag_r[DIV_STEPS];
    out_rnd  = div_q_r[DIV_STEPS] + QW'(1);
    out_full = out_rnd[QW-1:1];
    priority if (out_tag.big) begin
      out_y_nxt = out_tag.neg ? '0 : OUT_MAX;
    end else if (out_full[OUT_WIDTH]) begin
      out_y_nxt = OUT_MAX;
    end else begin
      out_y_nxt = out_full[OUT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_y_r    <= out_y_nxt;
      out_last_r <= out_tag.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_y_value = out_y_r;
  assign out_last    = out_last_r;

  // The reduced argument always lands below ln2.
  a_red_below_ln2: assert property (@(posedge clk) disable iff (!rst_n)
    red_v_r[RED_BITS] |-> red_rem_r[RED_BITS] < arg_t'(Q_LN2))
    else $error("range reduction left a remainder of ln2 or more");

  // The last series term has vanished for every reduced argument.
  a_series_converged: assert property (@(posedge clk) disable iff (!rst_n)
    chain_v[TAYLOR_TERMS] |-> chain_term[TAYLOR_TERMS] == '0)
    else $error("final series term is not zero");

  // exp(-|x|) never exceeds one.
  a_exp_at_most_one: assert property (@(posedge clk) disable iff (!rst_n)
    exp_v_r |-> exp_e_r <= Q_ONE)
    else $error("exponential estimate above one");

  // The divider remainder is below the divisor after the last step.
  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_v_r[DIV_STEPS] |-> div_rem_r[DIV_STEPS] < div_d_r[DIV_STEPS])
    else $error("divider remainder reached the divisor");

endmodule
